// File: rtl/core/tskf_pkg.sv
// ----------------------------------------------------------------------------
// tskf_pkg
// types, codes, saturation helpers and the microcode table of the filter
// ----------------------------------------------------------------------------
package tskf_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_A00    = 3'd0;
	localparam logic [2:0] REG_A01    = 3'd1;
	localparam logic [2:0] REG_A10    = 3'd2;
	localparam logic [2:0] REG_A11    = 3'd3;
	localparam logic [2:0] REG_QNOISE = 3'd4;
	localparam logic [2:0] REG_RACCEL = 3'd5;
	localparam logic [2:0] REG_RGYRO  = 3'd6;

	localparam logic [31:0] A_DIAG_RST = 32'd65536;
	localparam logic [47:0] NOISE_RST  = 48'd282627133;
	localparam logic [2:0]  ACCEL_AXES = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_DEN,
		OP_STO,
		OP_JMP,
		OP_JDZ,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] dst;
		logic [4:0] sa;
		logic [4:0] sb;
		logic [6:0] tgt;
	} cw_t;

	// operand sources: working registers below 16, fixed sources from 16 up
	localparam logic [4:0] S_X0   = 5'd0;
	localparam logic [4:0] S_X1   = 5'd1;
	localparam logic [4:0] S_P0   = 5'd2;
	localparam logic [4:0] S_P1   = 5'd3;
	localparam logic [4:0] S_P2   = 5'd4;
	localparam logic [4:0] S_P3   = 5'd5;
	localparam logic [4:0] S_T6   = 5'd6;
	localparam logic [4:0] S_T7   = 5'd7;
	localparam logic [4:0] S_XP0  = 5'd8;
	localparam logic [4:0] S_XP1  = 5'd9;
	localparam logic [4:0] S_M00  = 5'd10;
	localparam logic [4:0] S_M01  = 5'd11;
	localparam logic [4:0] S_M10  = 5'd12;
	localparam logic [4:0] S_M11  = 5'd13;
	localparam logic [4:0] S_ERR  = 5'd14;
	localparam logic [4:0] S_A00  = 5'd16;
	localparam logic [4:0] S_A01  = 5'd17;
	localparam logic [4:0] S_A10  = 5'd18;
	localparam logic [4:0] S_A11  = 5'd19;
	localparam logic [4:0] S_Q    = 5'd20;
	localparam logic [4:0] S_R    = 5'd21;
	localparam logic [4:0] S_SMP  = 5'd22;
	localparam logic [4:0] S_ZERO = 5'd23;
	localparam logic [4:0] S_ROW0 = 5'd24;
	localparam logic [4:0] S_ROW1 = 5'd25;
	localparam logic [4:0] S_ROW2 = 5'd26;
	localparam logic [4:0] S_ROW3 = 5'd27;
	localparam logic [4:0] S_ROW4 = 5'd28;
	localparam logic [4:0] S_ROW5 = 5'd29;

	// gain registers reuse the m00 and m01 slots
	localparam logic [4:0] S_K0 = S_M00;
	localparam logic [4:0] S_K1 = S_M01;

	localparam logic [6:0] L_KZERO = 7'd44;
	localparam logic [6:0] L_UPD   = 7'd46;

	function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
		logic signed [47:0] r;
		if (v > 51'sh0_7FFF_FFFF_FFFF) begin
			r = 48'sh7FFF_FFFF_FFFF;
		end else if (v < 51'sh7_8000_0000_0000) begin
			r = 48'sh8000_0000_0000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sh0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < 48'shFFFF_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// signed result from a magnitude of at most 2^48
	function automatic logic signed [47:0] signsat(input logic [48:0] m, input logic neg);
		logic signed [47:0] r;
		if (neg) begin
			r = (m > 49'h0_8000_0000_0000) ? 48'sh8000_0000_0000 : -m[47:0];
		end else begin
			r = (m > 49'h0_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : m[47:0];
		end
		return r;
	endfunction

	function automatic logic [47:0] mag48(input logic signed [49:0] v);
		logic signed [49:0] n;
		n = -v;
		return v[49] ? n[47:0] : v[47:0];
	endfunction

	function automatic cw_t mk(input op_t op, input logic [4:0] d, input logic [4:0] a,
			input logic [4:0] b, input logic [6:0] t);
		cw_t c;
		c.op  = op;
		c.dst = d[3:0];
		c.sa  = a;
		c.sb  = b;
		c.tgt = t;
		return c;
	endfunction

	// filter program: load, predict, gain, update, store
	function automatic cw_t ucode(input logic [6:0] step);
		cw_t c;
		unique case (step)
			7'd0:  c = mk(OP_ADD, S_X0, S_ROW0, S_ZERO, '0);
			7'd1:  c = mk(OP_ADD, S_X1, S_ROW1, S_ZERO, '0);
			7'd2:  c = mk(OP_ADD, S_P0, S_ROW2, S_ZERO, '0);
			7'd3:  c = mk(OP_ADD, S_P1, S_ROW3, S_ZERO, '0);
			7'd4:  c = mk(OP_ADD, S_P2, S_ROW4, S_ZERO, '0);
			7'd5:  c = mk(OP_ADD, S_P3, S_ROW5, S_ZERO, '0);
			// predicted state
			7'd6:  c = mk(OP_MUL, S_T6, S_A00, S_X0, '0);
			7'd7:  c = mk(OP_MUL, S_T7, S_A01, S_X1, '0);
			7'd8:  c = mk(OP_ADD, S_XP0, S_T6, S_T7, '0);
			7'd9:  c = mk(OP_MUL, S_T6, S_A10, S_X0, '0);
			7'd10: c = mk(OP_MUL, S_T7, S_A11, S_X1, '0);
			7'd11: c = mk(OP_ADD, S_XP1, S_T6, S_T7, '0);
			// m = a p
			7'd12: c = mk(OP_MUL, S_T6, S_A00, S_P0, '0);
			7'd13: c = mk(OP_MUL, S_T7, S_A01, S_P2, '0);
			7'd14: c = mk(OP_ADD, S_M00, S_T6, S_T7, '0);
			7'd15: c = mk(OP_MUL, S_T6, S_A00, S_P1, '0);
			7'd16: c = mk(OP_MUL, S_T7, S_A01, S_P3, '0);
			7'd17: c = mk(OP_ADD, S_M01, S_T6, S_T7, '0);
			7'd18: c = mk(OP_MUL, S_T6, S_A10, S_P0, '0);
			7'd19: c = mk(OP_MUL, S_T7, S_A11, S_P2, '0);
			7'd20: c = mk(OP_ADD, S_M10, S_T6, S_T7, '0);
			7'd21: c = mk(OP_MUL, S_T6, S_A10, S_P1, '0);
			7'd22: c = mk(OP_MUL, S_T7, S_A11, S_P3, '0);
			7'd23: c = mk(OP_ADD, S_M11, S_T6, S_T7, '0);
			// predicted covariance m a^t plus q
			7'd24: c = mk(OP_MUL, S_T6, S_M00, S_A00, '0);
			7'd25: c = mk(OP_MUL, S_T7, S_M01, S_A01, '0);
			7'd26: c = mk(OP_ADD, S_T6, S_T6, S_T7, '0);
			7'd27: c = mk(OP_ADD, S_P0, S_T6, S_Q, '0);
			7'd28: c = mk(OP_MUL, S_T6, S_M00, S_A10, '0);
			7'd29: c = mk(OP_MUL, S_T7, S_M01, S_A11, '0);
			7'd30: c = mk(OP_ADD, S_P1, S_T6, S_T7, '0);
			7'd31: c = mk(OP_MUL, S_T6, S_M10, S_A00, '0);
			7'd32: c = mk(OP_MUL, S_T7, S_M11, S_A01, '0);
			7'd33: c = mk(OP_ADD, S_P2, S_T6, S_T7, '0);
			7'd34: c = mk(OP_MUL, S_T6, S_M10, S_A10, '0);
			7'd35: c = mk(OP_MUL, S_T7, S_M11, S_A11, '0);
			7'd36: c = mk(OP_ADD, S_T6, S_T6, S_T7, '0);
			7'd37: c = mk(OP_ADD, S_P3, S_T6, S_Q, '0);
			// residual and gain
			7'd38: c = mk(OP_SUB, S_ERR, S_SMP, S_XP0, '0);
			7'd39: c = mk(OP_DEN, S_ZERO, S_P0, S_R, '0);
			7'd40: c = mk(OP_JDZ, S_ZERO, S_ZERO, S_ZERO, L_KZERO);
			7'd41: c = mk(OP_DIV, S_K0, S_P0, S_ZERO, '0);
			7'd42: c = mk(OP_DIV, S_K1, S_P2, S_ZERO, '0);
			7'd43: c = mk(OP_JMP, S_ZERO, S_ZERO, S_ZERO, L_UPD);
			7'd44: c = mk(OP_ADD, S_K0, S_ZERO, S_ZERO, '0);
			7'd45: c = mk(OP_ADD, S_K1, S_ZERO, S_ZERO, '0);
			// state update
			7'd46: c = mk(OP_MUL, S_T6, S_K0, S_ERR, '0);
			7'd47: c = mk(OP_ADD, S_X0, S_XP0, S_T6, '0);
			7'd48: c = mk(OP_MUL, S_T6, S_K1, S_ERR, '0);
			7'd49: c = mk(OP_ADD, S_X1, S_XP1, S_T6, '0);
			// covariance update
			7'd50: c = mk(OP_MUL, S_T6, S_K0, S_P0, '0);
			7'd51: c = mk(OP_SUB, S_M10, S_P0, S_T6, '0);
			7'd52: c = mk(OP_MUL, S_T6, S_K0, S_P1, '0);
			7'd53: c = mk(OP_SUB, S_M11, S_P1, S_T6, '0);
			7'd54: c = mk(OP_MUL, S_T6, S_K1, S_P0, '0);
			7'd55: c = mk(OP_SUB, S_P2, S_P2, S_T6, '0);
			7'd56: c = mk(OP_MUL, S_T6, S_K1, S_P1, '0);
			7'd57: c = mk(OP_SUB, S_P3, S_P3, S_T6, '0);
			// write-back row
			7'd58: c = mk(OP_STO, 5'd0, S_X0, S_ZERO, '0);
			7'd59: c = mk(OP_STO, 5'd1, S_X1, S_ZERO, '0);
			7'd60: c = mk(OP_STO, 5'd2, S_M10, S_ZERO, '0);
			7'd61: c = mk(OP_STO, 5'd3, S_M11, S_ZERO, '0);
			7'd62: c = mk(OP_STO, 5'd4, S_P2, S_ZERO, '0);
			7'd63: c = mk(OP_STO, 5'd5, S_P3, S_ZERO, '0);
			default: c = mk(OP_DONE, S_ZERO, S_ZERO, S_ZERO, '0);
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/two_state_kalman_filter_multi_axis.sv
// ----------------------------------------------------------------------------
// two_state_kalman_filter_multi_axis
// per-axis two-state kalman filter in fixed point, run by a microcoded sequencer
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      beat contents
//  s_axis    in   s_axis_tvalid/s_axis_tready    axis [2:0], sample [18:3]
//  m_axis    out  m_axis_tvalid/m_axis_tready    estimate [31:0]
//  cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// one item runs the 65-step program: 26 multiplies on the shared 24x24 multiplier and two
// divides on the bit-serial divider, which a zero denominator skips.
// an axis out of range returns zero without running the program.
// reset restores the transition, noise registers and marks every axis as fresh.
// the next item is taken while a result still waits on m_axis; a full output register
// holds the sequencer at its last step.

module two_state_kalman_filter_multi_axis #(
	parameter int NUM_AXES  = 5,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // axis [2:0], sample [18:3], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // estimate [31:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int NW = 48 + FRAC_BITS;          // divider dividend width
	localparam int CW = $clog2(NW + 1);
	localparam logic [47:0]  ONE  = 48'(1) << FRAC_BITS;
	localparam logic [95:0]  HALF = 96'(1) << (FRAC_BITS - 1);
	localparam logic [287:0] RST_ROW = {ONE, 48'd0, 48'd0, ONE, 48'd0, 48'd0};

	// configuration
	logic [31:0] a00_q, a01_q, a10_q, a11_q;
	logic [47:0] qn_q, racc_q, rgyr_q;

	// sequencer
	tskf_pkg::state_t st_q, st_d;
	tskf_pkg::cw_t    cw;
	logic [6:0]       step_q;
	logic             ph_q;       // 0: operand read, 1: execute
	logic             busy_q;     // multiplier or divider running
	logic [CW-1:0]    cnt_q;
	logic             exec;

	// item context
	logic [AW-1:0]      addr_q;
	logic               gyro_q;
	logic signed [15:0] smp_q;
	logic [2:0]         in_axis;
	logic               in_acc;
	logic               axis_ok;

	// per-axis state memory, one row of x0 x1 p00 p01 p10 p11
	logic [287:0]        smem [NUM_AXES];
	logic [287:0]        row_q;
	logic                rvld_q;
	logic [NUM_AXES-1:0] vld_q;
	logic signed [47:0]  wb_q [6];

	// working register file
	logic signed [47:0] rf [16];
	logic signed [47:0] rda_q, rdb_q;
	logic               rf_we;
	logic signed [47:0] rf_wd;

	// operands and results
	logic signed [49:0] opa, opb;
	logic signed [47:0] sum_r, dif_r;
	logic signed [49:0] den_q;

	// multiplier: four 24x24 partial products into a rounded accumulator
	logic [47:0]        ua_q, ub_q;
	logic               neg_q;
	logic [95:0]        acc_q;
	logic [23:0]        pa, pb;
	logic [47:0]        pp;
	logic [6:0]         psh;
	logic [95:0]        mshift;
	logic signed [47:0] mres;

	// divider: restoring, one quotient bit a cycle
	logic [NW-1:0]      num_q;
	logic [50:0]        rem_q;
	logic [49:0]        ud_q;
	logic [50:0]        rem2;
	logic               dge;
	logic [48:0]        dq;
	logic signed [47:0] dres;

	// output
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [31:0] est_q;
	logic        out_load;

	function automatic logic signed [49:0] pick(input logic [4:0] sel,
			input logic signed [47:0] rd);
		logic signed [49:0] v;
		logic signed [49:0] s;
		s = 50'(smp_q);
		if (!sel[4]) begin
			v = 50'(rd);
		end else begin
			unique case (sel)
				tskf_pkg::S_A00:  v = 50'($signed(a00_q));
				tskf_pkg::S_A01:  v = 50'($signed(a01_q));
				tskf_pkg::S_A10:  v = 50'($signed(a10_q));
				tskf_pkg::S_A11:  v = 50'($signed(a11_q));
				tskf_pkg::S_Q:    v = $signed({2'b00, qn_q});
				tskf_pkg::S_R:    v = $signed({2'b00, gyro_q ? rgyr_q : racc_q});
				tskf_pkg::S_SMP:  v = s <<< FRAC_BITS;
				tskf_pkg::S_ROW0: v = 50'($signed(rvld_q ? row_q[47:0]    : RST_ROW[47:0]));
				tskf_pkg::S_ROW1: v = 50'($signed(rvld_q ? row_q[95:48]   : RST_ROW[95:48]));
				tskf_pkg::S_ROW2: v = 50'($signed(rvld_q ? row_q[143:96]  : RST_ROW[143:96]));
				tskf_pkg::S_ROW3: v = 50'($signed(rvld_q ? row_q[191:144] : RST_ROW[191:144]));
				tskf_pkg::S_ROW4: v = 50'($signed(rvld_q ? row_q[239:192] : RST_ROW[239:192]));
				tskf_pkg::S_ROW5: v = 50'($signed(rvld_q ? row_q[287:240] : RST_ROW[287:240]));
				default:          v = '0;
			endcase
		end
		return v;
	endfunction

	assign in_axis = s_axis_tdata[2:0];
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign axis_ok = {29'd0, in_axis} < 32'(NUM_AXES);
	assign cw      = tskf_pkg::ucode(step_q);
	assign exec    = (st_q == tskf_pkg::ST_RUN) && ph_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			tskf_pkg::ST_IDLE: begin
				if (in_acc) st_d = axis_ok ? tskf_pkg::ST_RUN : tskf_pkg::ST_OUT;
			end
			tskf_pkg::ST_RUN: begin
				if (exec && cw.op == tskf_pkg::OP_DONE) st_d = tskf_pkg::ST_OUT;
			end
			tskf_pkg::ST_OUT: begin
				if (out_load) st_d = tskf_pkg::ST_IDLE;
			end
			default: st_d = tskf_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_axis_tready = (st_q == tskf_pkg::ST_IDLE);
		out_load      = (st_q == tskf_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);
		cfg_ready     = 1'b1;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// operands, alu, multiplier and divider combinational parts
	always_comb begin
		opa   = pick(cw.sa, rda_q);
		opb   = pick(cw.sb, rdb_q);
		sum_r = tskf_pkg::sat48(51'(opa) + 51'(opb));
		dif_r = tskf_pkg::sat48(51'(opa) - 51'(opb));

		pa = cnt_q[1] ? ua_q[47:24] : ua_q[23:0];
		pb = cnt_q[0] ? ub_q[47:24] : ub_q[23:0];
		pp = 48'(pa) * 48'(pb);
		unique case (cnt_q[1:0])
			2'b00:   psh = 7'd0;
			2'b11:   psh = 7'd48;
			default: psh = 7'd24;
		endcase
		mshift = acc_q >> FRAC_BITS;
		if (neg_q) begin
			mres = (mshift > 96'h8000_0000_0000) ? 48'sh8000_0000_0000 : -mshift[47:0];
		end else begin
			mres = (mshift > 96'h7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF : mshift[47:0];
		end

		rem2 = {rem_q[49:0], num_q[NW-1]};
		dge  = rem2 >= {1'b0, ud_q};
		// round half away from zero on the remainder
		dq   = 49'(num_q[47:0]) + 49'({rem_q, 1'b0} >= {2'b00, ud_q});
		if ((num_q >> 48) != '0) begin
			dres = neg_q ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		end else begin
			dres = tskf_pkg::signsat(dq, neg_q);
		end

		rf_we = 1'b0;
		rf_wd = sum_r;
		if (exec) begin
			unique case (cw.op)
				tskf_pkg::OP_ADD: rf_we = 1'b1;
				tskf_pkg::OP_SUB: begin
					rf_we = 1'b1;
					rf_wd = dif_r;
				end
				tskf_pkg::OP_MUL: begin
					rf_we = busy_q && (cnt_q == CW'(4));
					rf_wd = mres;
				end
				tskf_pkg::OP_DIV: begin
					rf_we = busy_q && (cnt_q == CW'(NW));
					rf_wd = dres;
				end
				default: rf_we = 1'b0;
			endcase
		end
	end

	// working registers, registered reads at the current step's sources
	always_ff @(posedge clk) begin
		if (rf_we) rf[cw.dst] <= rf_wd;
		rda_q <= rf[cw.sa[3:0]];
		rdb_q <= rf[cw.sb[3:0]];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= tskf_pkg::ST_IDLE;
			step_q      <= '0;
			ph_q        <= 1'b0;
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			a00_q       <= tskf_pkg::A_DIAG_RST;
			a01_q       <= '0;
			a10_q       <= '0;
			a11_q       <= tskf_pkg::A_DIAG_RST;
			qn_q        <= tskf_pkg::NOISE_RST;
			racc_q      <= tskf_pkg::NOISE_RST;
			rgyr_q      <= tskf_pkg::NOISE_RST;
		end else begin
			st_q <= st_d;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tskf_pkg::REG_A00:    a00_q  <= cfg_data[31:0];
					tskf_pkg::REG_A01:    a01_q  <= cfg_data[31:0];
					tskf_pkg::REG_A10:    a10_q  <= cfg_data[31:0];
					tskf_pkg::REG_A11:    a11_q  <= cfg_data[31:0];
					tskf_pkg::REG_QNOISE: qn_q   <= cfg_data;
					tskf_pkg::REG_RACCEL: racc_q <= cfg_data;
					tskf_pkg::REG_RGYRO:  rgyr_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_acc) begin
				step_q <= '0;
				ph_q   <= 1'b0;
				busy_q <= 1'b0;
			end else if (st_q == tskf_pkg::ST_RUN) begin
				if (!ph_q) begin
					ph_q <= 1'b1;
				end else begin
					unique case (cw.op)
						tskf_pkg::OP_MUL: begin
							if (!busy_q) begin
								busy_q <= 1'b1;
								cnt_q  <= '0;
							end else if (cnt_q != CW'(4)) begin
								cnt_q <= cnt_q + 1'b1;
							end else begin
								busy_q <= 1'b0;
								step_q <= step_q + 1'b1;
								ph_q   <= 1'b0;
							end
						end
						tskf_pkg::OP_DIV: begin
							if (!busy_q) begin
								busy_q <= 1'b1;
								cnt_q  <= '0;
							end else if (cnt_q != CW'(NW)) begin
								cnt_q <= cnt_q + 1'b1;
							end else begin
								busy_q <= 1'b0;
								step_q <= step_q + 1'b1;
								ph_q   <= 1'b0;
							end
						end
						tskf_pkg::OP_JMP: begin
							step_q <= cw.tgt;
							ph_q   <= 1'b0;
						end
						tskf_pkg::OP_JDZ: begin
							step_q <= (den_q == '0) ? cw.tgt : step_q + 1'b1;
							ph_q   <= 1'b0;
						end
						tskf_pkg::OP_DONE: begin
							vld_q[addr_q] <= 1'b1;
						end
						default: begin
							step_q <= step_q + 1'b1;
							ph_q   <= 1'b0;
						end
					endcase
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers and state memory
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= AW'(in_axis);
			gyro_q <= in_axis >= tskf_pkg::ACCEL_AXES;
			smp_q  <= $signed(s_axis_tdata[18:3]);
			est_q  <= '0;
			row_q  <= smem[AW'(in_axis)];
			rvld_q <= vld_q[AW'(in_axis)];
		end

		if (exec) begin
			unique case (cw.op)
				tskf_pkg::OP_MUL: begin
					if (!busy_q) begin
						ua_q  <= tskf_pkg::mag48(opa);
						ub_q  <= tskf_pkg::mag48(opb);
						neg_q <= opa[49] ^ opb[49];
						acc_q <= HALF;
					end else if (cnt_q != CW'(4)) begin
						acc_q <= acc_q + (96'(pp) << psh);
					end
				end
				tskf_pkg::OP_DIV: begin
					if (!busy_q) begin
						num_q <= NW'(tskf_pkg::mag48(opa)) << FRAC_BITS;
						ud_q  <= den_q[49] ? 50'(-den_q) : den_q;
						rem_q <= '0;
						neg_q <= opa[49] ^ den_q[49];
					end else if (cnt_q != CW'(NW)) begin
						rem_q <= dge ? rem2 - {1'b0, ud_q} : rem2;
						num_q <= {num_q[NW-2:0], dge};
					end
				end
				tskf_pkg::OP_DEN: den_q <= opa + opb;
				tskf_pkg::OP_STO: wb_q[cw.dst[2:0]] <= opa[47:0];
				tskf_pkg::OP_DONE: begin
					smem[addr_q] <= {wb_q[5], wb_q[4], wb_q[3], wb_q[2], wb_q[1], wb_q[0]};
					est_q        <= tskf_pkg::sat32(wb_q[0]);
				end
				default: ;
			endcase
		end

		if (out_load) out_data_q <= est_q;
	end

endmodule
